// File: sv/bounded_id_set_table_assert.svh
// Assertion macros shared by the checker of the bounded identifier set table.
// No dependencies; the including scope must provide clk and rst_n.
`ifndef BOUNDED_ID_SET_TABLE_ASSERT_SVH
`define BOUNDED_ID_SET_TABLE_ASSERT_SVH

// same-cycle implication, quiet during reset
`define BIDST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define BIDST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bidst_pkg.sv
// Shared types and constants for the bounded identifier set table.
// No dependencies; used by the cell, the top level and the checker.
package bidst_pkg;

  localparam int ID_W         = 32;
  localparam int SLOT_W       = 6;
  localparam int OUT_CNT_W    = 7;
  localparam int CAPACITY_DEF = 64;
  localparam logic [ID_W-1:0] EMPTY_ID = '1;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_INVALID   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              capture;  // latch match flags
    logic              wr_add;   // append at slot == count
    logic              wr_del;   // matching slot takes the last entry
    logic [ID_W-1:0]   key;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   wdata;
  } cell_ctl_t;

endpackage

// File: sv/bidst_cell.sv
// One slot of the identifier table: entry register, compare and match flags.
// Depends on bidst_pkg.
module bidst_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bidst_pkg::cell_ctl_t        ctl,
  input  logic [CNT_W-1:0]            count,
  output logic                        hit_o,
  output logic                        rd_o,
  output logic [bidst_pkg::ID_W-1:0]  rd_term_o,
  output logic [bidst_pkg::ID_W-1:0]  last_term_o
);

  logic [bidst_pkg::ID_W-1:0] entry_r;
  logic                       hit_r;
  logic                       rd_r;
  logic                       last_r;
  logic                       occupied;
  logic                       is_tail;
  logic                       is_append;

  assign occupied  = CNT_W'(IDX) < count;
  assign is_tail   = ((CNT_W+1)'(IDX) + (CNT_W+1)'(1)) == {1'b0, count};
  assign is_append = CNT_W'(IDX) == count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      rd_r   <= 1'b0;
      last_r <= 1'b0;
    end else if (ctl.capture) begin
      hit_r  <= occupied && (entry_r == ctl.key);
      rd_r   <= occupied && (32'(ctl.slot) == 32'(IDX));
      last_r <= is_tail;
    end
  end

  // slots at or above count are never looked at, so no reset on the entry
  always_ff @(posedge clk) begin
    if (ctl.wr_add && is_append) begin
      entry_r <= ctl.wdata;
    end else if (ctl.wr_del && hit_r) begin
      entry_r <= ctl.wdata;
    end
  end

  assign hit_o       = hit_r;
  assign rd_o        = rd_r;
  assign rd_term_o   = rd_r ? entry_r : '0;
  assign last_term_o = last_r ? entry_r : '0;

endmodule

// File: sv/bounded_id_set_table.sv
// Bounded identifier set table: row of slot cells plus command controller.
// Depends on bidst_pkg and bidst_cell.
//
//  channel | ports              | payload (lsb first)
//  --------+--------------------+-------------------------------------------------
//  in      | in_tvalid/tready   | command[1:0] item_id[33:2] slot_index[39:34]
//  out     | out_tvalid/tready  | status[1:0] found[2] id_out[34:3] member_count[41:35]
//
// Each command passes through S_MATCH, which compares the key against every slot
// in parallel and latches the match flags in the cells, and S_APPLY, which reduces
// the flags, updates the table and loads the result register. The next command is
// taken in S_APPLY. A result held in the output register stalls only S_APPLY.
// Synchronous active-low reset empties the set; no clearing pass is needed.
module bounded_id_set_table #(
  parameter int CAPACITY = bidst_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // command, item_id, slot_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status, found, id_out, member_count, zero pad
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int ID_W  = bidst_pkg::ID_W;

  typedef enum logic [1:0] {S_IDLE, S_MATCH, S_APPLY} state_t;

  state_t                         state_r;
  bidst_pkg::cmd_t                cmd_r;
  logic [ID_W-1:0]                id_r;
  logic [bidst_pkg::SLOT_W-1:0]   slot_r;
  logic [CNT_W-1:0]               count_r, count_nxt;

  logic                           out_valid_r;
  bidst_pkg::status_t             status_r, status_nxt;
  logic                           found_r, found_nxt;
  logic [ID_W-1:0]                id_out_r, id_out_nxt;

  logic                           in_acc;
  logic                           go;
  logic                           add_ok;
  logic                           del_ok;

  logic [CAPACITY-1:0]            hit_vec;
  logic [CAPACITY-1:0]            rd_vec;
  logic [ID_W-1:0]                rd_term  [CAPACITY];
  logic [ID_W-1:0]                last_term[CAPACITY];
  logic [ID_W-1:0]                rd_data;
  logic [ID_W-1:0]                last_data;
  logic                           any_hit;
  logic                           rd_any;

  bidst_pkg::cell_ctl_t           ctl;

  assign go        = (state_r == S_APPLY) && (!out_valid_r || out_tready);
  assign in_tready = (state_r == S_IDLE) || go;
  assign in_acc    = in_tvalid && in_tready;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      bidst_cell #(
        .IDX   (gi),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .count       (count_r),
        .hit_o       (hit_vec[gi]),
        .rd_o        (rd_vec[gi]),
        .rd_term_o   (rd_term[gi]),
        .last_term_o (last_term[gi])
      );
    end
  endgenerate

  // at most one cell raises each flag, so an OR picks its entry
  always_comb begin
    rd_data   = '0;
    last_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data   = rd_data | rd_term[i];
      last_data = last_data | last_term[i];
    end
  end

  assign any_hit = |hit_vec;
  assign rd_any  = |rd_vec;

  always_comb begin
    status_nxt = bidst_pkg::ST_OK;
    found_nxt  = 1'b0;
    id_out_nxt = bidst_pkg::EMPTY_ID;
    add_ok     = 1'b0;
    del_ok     = 1'b0;
    case (cmd_r)
      bidst_pkg::CMD_ADD: begin
        if (id_r == bidst_pkg::EMPTY_ID) begin
          status_nxt = bidst_pkg::ST_INVALID;
        end else if (count_r == CNT_W'(CAPACITY)) begin
          status_nxt = bidst_pkg::ST_FULL;
        end else if (!any_hit) begin
          add_ok = 1'b1;
        end
      end
      bidst_pkg::CMD_DELETE, bidst_pkg::CMD_QUERY: begin
        if (id_r == bidst_pkg::EMPTY_ID) begin
          status_nxt = bidst_pkg::ST_INVALID;
        end else if (!any_hit) begin
          status_nxt = bidst_pkg::ST_NOT_FOUND;
        end else begin
          found_nxt = 1'b1;
          if (cmd_r == bidst_pkg::CMD_DELETE) begin
            id_out_nxt = id_r;
            del_ok     = 1'b1;
          end
        end
      end
      bidst_pkg::CMD_READ: begin
        if (rd_any) begin
          found_nxt  = 1'b1;
          id_out_nxt = rd_data;
        end else begin
          status_nxt = bidst_pkg::ST_INVALID;
        end
      end
      default: begin
        status_nxt = bidst_pkg::ST_INVALID;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (go && add_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (go && del_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    ctl.capture = (state_r == S_MATCH);
    ctl.wr_add  = go && add_ok;
    ctl.wr_del  = go && del_ok;
    ctl.key     = id_r;
    ctl.slot    = slot_r;
    ctl.wdata   = (cmd_r == bidst_pkg::CMD_ADD) ? id_r : last_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_MATCH;
          end
        end
        S_MATCH: begin
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          if (go) begin
            state_r <= in_acc ? S_MATCH : S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= bidst_pkg::cmd_t'(in_tdata[1:0]);
      id_r   <= in_tdata[33:2];
      slot_r <= in_tdata[39:34];
    end
    if (go) begin
      status_r <= status_nxt;
      found_r  <= found_nxt;
      id_out_r <= id_out_nxt;
    end
  end

  logic [bidst_pkg::OUT_CNT_W-1:0] count_out;
  logic [CNT_W-1:0]                count_held_r;

  always_ff @(posedge clk) begin
    if (go) begin
      count_held_r <= count_nxt;
    end
  end

  assign count_out  = bidst_pkg::OUT_CNT_W'(32'(count_held_r));
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, count_out, id_out_r, found_r, status_r};

endmodule

// File: sv/bidst_checker.sv
// Port-level checks on the bounded identifier set table, bound to the top level.
// Depends on bidst_pkg and bounded_id_set_table_assert.svh.
`include "bounded_id_set_table_assert.svh"

module bidst_checker #(
  parameter int CAPACITY = bidst_pkg::CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  logic out_hold;
  logic out_err;

  assign out_hold = out_tvalid && !out_tready;
  assign out_err  = out_tvalid && (out_tdata[1:0] != bidst_pkg::ST_OK);

  `BIDST_ASSERT_NEXT(a_out_hold, out_hold, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `BIDST_ASSERT_NOW(a_count_cap, out_tvalid, 32'(out_tdata[41:35]) <= 32'(CAPACITY % 128), "member count above capacity")
  `BIDST_ASSERT_NOW(a_found_ok, out_tvalid && out_tdata[2], out_tdata[1:0] == bidst_pkg::ST_OK, "found with error status")
  `BIDST_ASSERT_NOW(a_err_empty, out_err, !out_tdata[2] && (out_tdata[34:3] == bidst_pkg::EMPTY_ID), "error result carries an id")
  `BIDST_ASSERT_NEXT(a_one_cmd, in_tvalid && in_tready, !in_tready, "command taken in back-to-back cycles")

endmodule

bind bounded_id_set_table bidst_checker #(
  .CAPACITY (CAPACITY)
) u_bidst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: verif/tb_bounded_id_set_table.sv
// Self-checking testbench for the bounded identifier set table: directed and random stream traffic
// on both channels, with every transaction checked against a behavioural model of the set.
// Depends on bidst_pkg and the bounded_id_set_table RTL.
module tb_bounded_id_set_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CMDS   = 1900;
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_CYC   = 20;

  typedef struct {
    bidst_pkg::cmd_t                cmd;
    logic [bidst_pkg::ID_W-1:0]     id;
    logic [bidst_pkg::SLOT_W-1:0]   idx;
    int unsigned                    gap;    // idle cycles before this command is offered
    bit                             pause;  // hold off until all results are back
  } set_cmd_t;

  typedef struct {
    bidst_pkg::status_t               status;
    logic                             found;
    logic [bidst_pkg::ID_W-1:0]       id_out;
    logic [bidst_pkg::OUT_CNT_W-1:0]  member_count;
  } set_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // command, item_id, slot_index
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // status, found, id_out, member_count, zero pad

  set_cmd_t    cmd_q[$];
  set_result_t result_q[$];

  // behavioural copy of the table
  logic [bidst_pkg::ID_W-1:0] shadow_ids[bidst_pkg::CAPACITY_DEF];
  int                         shadow_count;

  set_cmd_t                   cur;
  bit                         in_taken;
  bit                         gap_armed;
  int unsigned                gap_left;
  int unsigned                stall_left;
  int unsigned                results_seen;
  int unsigned                idle_cycles;
  int unsigned                errors;
  int unsigned                n_cmds;
  logic [bidst_pkg::ID_W-1:0] id_pool[$];

  set_result_t                exp_res;
  logic [1:0]                 got_status;
  logic                       got_found;
  logic [bidst_pkg::ID_W-1:0] got_id;
  logic [6:0]                 got_count;

  bounded_id_set_table uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // Apply one command to the shadow table and return the result it should give.
  function automatic set_result_t apply_set_cmd(input bidst_pkg::cmd_t cmd,
                                                input logic [bidst_pkg::ID_W-1:0] id,
                                                input logic [bidst_pkg::SLOT_W-1:0] idx);
    set_result_t r;
    int pos;
    r.status = bidst_pkg::ST_OK;
    r.found  = 1'b0;
    r.id_out = bidst_pkg::EMPTY_ID;
    pos = -1;
    if (cmd != bidst_pkg::CMD_READ) begin
      for (int i = 0; i < shadow_count; i++) begin
        if (pos < 0 && shadow_ids[i] == id) pos = i;
      end
    end
    case (cmd)
      bidst_pkg::CMD_ADD: begin
        // reserved id is rejected ahead of the full check
        if (id == bidst_pkg::EMPTY_ID) r.status = bidst_pkg::ST_INVALID;
        else if (shadow_count >= bidst_pkg::CAPACITY_DEF) r.status = bidst_pkg::ST_FULL;
        else if (pos < 0) begin
          shadow_ids[shadow_count] = id;
          shadow_count++;
        end
      end
      bidst_pkg::CMD_DELETE, bidst_pkg::CMD_QUERY: begin
        if (id == bidst_pkg::EMPTY_ID) r.status = bidst_pkg::ST_INVALID;
        else if (pos < 0) r.status = bidst_pkg::ST_NOT_FOUND;
        else begin
          r.found = 1'b1;
          if (cmd == bidst_pkg::CMD_DELETE) begin
            // last entry fills the hole
            shadow_ids[pos] = shadow_ids[shadow_count-1];
            shadow_ids[shadow_count-1] = bidst_pkg::EMPTY_ID;
            shadow_count--;
            r.id_out = id;
          end
        end
      end
      default: begin
        if (int'(idx) < shadow_count) begin
          r.found  = 1'b1;
          r.id_out = shadow_ids[idx];
        end else begin
          r.status = bidst_pkg::ST_INVALID;
        end
      end
    endcase
    r.member_count = bidst_pkg::OUT_CNT_W'(shadow_count);
    return r;
  endfunction

  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_cmd(input bidst_pkg::cmd_t cmd,
                                    input logic [bidst_pkg::ID_W-1:0] id,
                                    input logic [bidst_pkg::SLOT_W-1:0] idx, input bit quiet);
    set_cmd_t c;
    c.cmd   = cmd;
    c.id    = id;
    c.idx   = idx;
    c.gap   = pick_gap(quiet);
    c.pause = 1'b0;
    cmd_q.push_back(c);
    n_cmds++;
  endfunction

  function automatic void queue_pause();
    set_cmd_t c;
    c.cmd   = bidst_pkg::CMD_QUERY;
    c.id    = '0;
    c.idx   = '0;
    c.gap   = 0;
    c.pause = 1'b1;
    cmd_q.push_back(c);
  endfunction

  function automatic logic [bidst_pkg::ID_W-1:0] fresh_id();
    logic [bidst_pkg::ID_W-1:0] id;
    id = $urandom;
    id_pool.push_back(id);
    if (id_pool.size() > 150) void'(id_pool.pop_front());
    return id;
  endfunction

  function automatic logic [bidst_pkg::ID_W-1:0] pool_id();
    if (id_pool.size() == 0) return $urandom;
    return id_pool[$urandom_range(0, id_pool.size() - 1)];
  endfunction

  // Known ids mostly, with the odd reserved or unrelated one.
  function automatic logic [bidst_pkg::ID_W-1:0] mixed_id();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return bidst_pkg::EMPTY_ID;
    if (r < 85) return pool_id();
    return $urandom;
  endfunction

  function automatic void build_stimulus();
    bit quiet;
    int unsigned len;
    int unsigned r;
    int unsigned k;
    logic [bidst_pkg::SLOT_W-1:0] idx;

    // directed: empty table, reserved id, ids at the extremes, swap-on-delete, read bound
    queue_cmd(bidst_pkg::CMD_ADD,    bidst_pkg::EMPTY_ID, 6'd0,  1'b0);
    queue_cmd(bidst_pkg::CMD_QUERY,  bidst_pkg::EMPTY_ID, 6'd0,  1'b0);
    queue_cmd(bidst_pkg::CMD_DELETE, bidst_pkg::EMPTY_ID, 6'd0,  1'b0);
    queue_cmd(bidst_pkg::CMD_READ,   '0,                  6'd0,  1'b0);
    queue_cmd(bidst_pkg::CMD_READ,   '1,                  6'd63, 1'b0);
    queue_cmd(bidst_pkg::CMD_QUERY,  32'h0,               6'd0,  1'b0);
    queue_cmd(bidst_pkg::CMD_DELETE, 32'h0,               6'd0,  1'b0);
    queue_cmd(bidst_pkg::CMD_ADD,    32'h0,               6'd0,  1'b0);
    queue_cmd(bidst_pkg::CMD_ADD,    32'hFFFF_FFFE,       6'd0,  1'b0);
    queue_cmd(bidst_pkg::CMD_ADD,    32'h8000_0000,       6'd0,  1'b0);
    queue_cmd(bidst_pkg::CMD_ADD,    32'h0,               6'd0,  1'b0);
    queue_cmd(bidst_pkg::CMD_QUERY,  32'h0,               6'd0,  1'b0);
    queue_cmd(bidst_pkg::CMD_QUERY,  32'hFFFF_FFFE,       6'd0,  1'b0);
    queue_cmd(bidst_pkg::CMD_READ,   '0,                  6'd2,  1'b0);
    queue_cmd(bidst_pkg::CMD_READ,   '0,                  6'd3,  1'b0);  // index equal to count
    queue_cmd(bidst_pkg::CMD_DELETE, 32'h0,               6'd0,  1'b0);
    queue_cmd(bidst_pkg::CMD_READ,   '0,                  6'd0,  1'b0);
    queue_cmd(bidst_pkg::CMD_DELETE, 32'h8000_0000,       6'd0,  1'b0);
    queue_cmd(bidst_pkg::CMD_DELETE, 32'hFFFF_FFFE,       6'd0,  1'b0);
    queue_cmd(bidst_pkg::CMD_READ,   '0,                  6'd0,  1'b0);
    queue_cmd(bidst_pkg::CMD_ADD,    32'h5555_5555,       6'd0,  1'b0);
    queue_cmd(bidst_pkg::CMD_ADD,    32'hAAAA_AAAA,       6'd0,  1'b0);
    queue_pause();

    while (n_cmds < NUM_CMDS + 22) begin
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1: begin
          // fill run; the long ones always reach a full table
          len = ($urandom_range(0, 1) != 0) ? $urandom_range(64, 72) : $urandom_range(8, 40);
          repeat (len) begin
            queue_cmd(bidst_pkg::CMD_ADD, fresh_id(), bidst_pkg::SLOT_W'($urandom), quiet);
          end
        end
        2: begin
          // delete every known id in random order
          while (id_pool.size() != 0) begin
            k = $urandom_range(0, id_pool.size() - 1);
            queue_cmd(bidst_pkg::CMD_DELETE, id_pool[k], bidst_pkg::SLOT_W'($urandom), quiet);
            id_pool.delete(k);
          end
        end
        default: begin
          if ($urandom_range(0, 15) == 0) queue_pause();
          len = $urandom_range(20, 60);
          repeat (len) begin
            r = $urandom_range(0, 99);
            idx = ($urandom_range(0, 99) < 60) ? bidst_pkg::SLOT_W'($urandom_range(0, 15)) :
                                                 bidst_pkg::SLOT_W'($urandom);
            if (r < 30)
              queue_cmd(bidst_pkg::CMD_ADD,
                        ($urandom_range(0, 9) < 7) ? mixed_id() : fresh_id(), idx, quiet);
            else if (r < 50)
              queue_cmd(bidst_pkg::CMD_DELETE, mixed_id(), idx, quiet);
            else if (r < 75)
              queue_cmd(bidst_pkg::CMD_QUERY, mixed_id(), idx, quiet);
            else
              queue_cmd(bidst_pkg::CMD_READ, $urandom, idx, quiet);
          end
        end
      endcase
    end
  endfunction

  // Driver: offers the next command on the falling edge once the last one has gone.
  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_taken)) begin
      if (cmd_q.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (cmd_q[0].pause) begin
        in_tvalid <= 1'b0;
        if (result_q.size() == 0) void'(cmd_q.pop_front());
      end else begin
        if (!gap_armed) begin
          gap_left  = cmd_q[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          cur       = cmd_q.pop_front();
          gap_armed = 1'b0;
          in_tdata  <= {cur.idx, cur.id, cur.cmd};
          in_tvalid <= 1'b1;
        end
      end
    end
  end

  // Result side back-pressure, with a calm window now and then.
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (((results_seen / 256) % 4) != 3 && $urandom_range(0, 99) < 25) begin
        r_stall: begin
          int unsigned r;
          r = $urandom_range(0, 99);
          stall_left = (r < 70) ? $urandom_range(0, 1) :
                       (r < 95) ? $urandom_range(2, 7) : $urandom_range(19, 49);
        end
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on accepted commands, checks results, and minds the watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken = in_tvalid && in_tready;
      if (in_taken) result_q.push_back(apply_set_cmd(cur.cmd, cur.id, cur.idx));
      if (out_tvalid && out_tready) begin
        got_status = out_tdata[1:0];
        got_found  = out_tdata[2];
        got_id     = out_tdata[34:3];
        got_count  = out_tdata[41:35];
        results_seen++;
        if (result_q.size() == 0) begin
          $error("result transaction with nothing outstanding: status %0d id_out %h count %0d",
                 got_status, got_id, got_count);
          errors++;
        end else begin
          exp_res = result_q.pop_front();
          if (got_status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, got_status);
            errors++;
          end
          if (got_found !== exp_res.found) begin
            $error("found: expected %0d, got %0d", exp_res.found, got_found);
            errors++;
          end
          if (got_id !== exp_res.id_out) begin
            $error("id_out: expected %h, got %h", exp_res.id_out, got_id);
            errors++;
          end
          if (got_count !== exp_res.member_count) begin
            $error("member_count: expected %0d, got %0d", exp_res.member_count, got_count);
            errors++;
          end
        end
      end
      if (in_taken || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $error("no transaction for %0d cycles", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    out_tready   = 1'b0;
    in_taken     = 1'b0;
    gap_armed    = 1'b0;
    gap_left     = 0;
    stall_left   = 0;
    results_seen = 0;
    idle_cycles  = 0;
    errors       = 0;
    n_cmds       = 0;
    shadow_count = 0;
    for (int i = 0; i < bidst_pkg::CAPACITY_DEF; i++) shadow_ids[i] = bidst_pkg::EMPTY_ID;
    build_stimulus();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() != 0 || in_tvalid || result_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
